/* rtl/deinterleave_aes_ctr_decrypt_core_macros.svh */
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef DEINTERLEAVE_AES_CTR_DECRYPT_CORE_MACROS_SVH
`define DEINTERLEAVE_AES_CTR_DECRYPT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define DAC_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
`define DAC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define DAC_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define DAC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/dac_pkg.sv */
package dac_pkg;

    localparam int BLOCK_BYTES_DEF   = 1024;
    localparam int QUARTER_BYTES_DEF = 256;
    localparam int AES_ROUNDS        = 10;

    // Configuration register indexes.
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam logic [63:0] IV_HIGH = 64'h72e067fbddcbcf77;
    localparam logic [63:0] IV_LOW  = 64'hebe8bc643f630d93;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon_of(input logic [3:0] rnd);
        case (rnd)
            4'd1:    rcon_of = 8'h01;
            4'd2:    rcon_of = 8'h02;
            4'd3:    rcon_of = 8'h04;
            4'd4:    rcon_of = 8'h08;
            4'd5:    rcon_of = 8'h10;
            4'd6:    rcon_of = 8'h20;
            4'd7:    rcon_of = 8'h40;
            4'd8:    rcon_of = 8'h80;
            4'd9:    rcon_of = 8'h1b;
            4'd10:   rcon_of = 8'h36;
            default: rcon_of = 8'h00;
        endcase
    endfunction

endpackage

/* rtl/dac_col_lane.sv */
// One column of an AES round: byte substitution, then MixColumns unless this is the final round.
module dac_col_lane (
    input  logic [31:0] i_col,
    input  logic        i_mix,
    output logic [31:0] o_col
);
    logic [7:0] a0, a1, a2, a3, all_x;

    always_comb begin
        a0 = dac_pkg::SBOX[i_col[31:24]];
        a1 = dac_pkg::SBOX[i_col[23:16]];
        a2 = dac_pkg::SBOX[i_col[15:8]];
        a3 = dac_pkg::SBOX[i_col[7:0]];
        all_x = a0 ^ a1 ^ a2 ^ a3;
        if (i_mix) begin
            o_col = {a0 ^ all_x ^ dac_pkg::xtime(a0 ^ a1),
                     a1 ^ all_x ^ dac_pkg::xtime(a1 ^ a2),
                     a2 ^ all_x ^ dac_pkg::xtime(a2 ^ a3),
                     a3 ^ all_x ^ dac_pkg::xtime(a3 ^ a0)};
        end else begin
            o_col = {a0, a1, a2, a3};
        end
    end
endmodule

/* rtl/dac_key_step.sv */
// Derives the next AES-128 round key from the current one.
module dac_key_step (
    input  logic [127:0] i_rk,
    input  logic [7:0]   i_rcon,
    output logic [127:0] o_rk
);
    logic [31:0] w3, t, n0, n1, n2, n3;

    always_comb begin
        w3 = i_rk[31:0];
        t  = {dac_pkg::SBOX[w3[23:16]], dac_pkg::SBOX[w3[15:8]],
              dac_pkg::SBOX[w3[7:0]], dac_pkg::SBOX[w3[31:24]]} ^ {i_rcon, 24'h000000};
        n0 = i_rk[127:96] ^ t;
        n1 = i_rk[95:64] ^ n0;
        n2 = i_rk[63:32] ^ n1;
        n3 = w3 ^ n2;
        o_rk = {n0, n1, n2, n3};
    end
endmodule

/* rtl/deinterleave_aes_ctr_decrypt_core.sv */
// Four-way byte deinterleave with AES-128 counter-mode decryption.
// The input channel (i_in_valid / o_in_ready) takes one 64-bit ciphertext beat per cycle
// while the block is collecting. After BLOCK_BYTES/8 beats the block stops accepting and
// produces BLOCK_BYTES/16 result beats on the output channel (o_out_valid / i_out_ready),
// each carrying 16 deinterleaved plaintext bytes; o_block_last marks the final one.
// Each chunk runs through a round-iterative AES: a load step into the state register plus
// ten round steps, each written back to it. The block takes no new input beats until the
// last chunk of the current block has been loaded into the output register.
// The four state columns of each round are handled by four parallel lanes, and their
// outputs are merged with the round key into the state register. The round key itself
// is derived on the fly, one step per round, so a key write takes effect from the next chunk loaded.
// While the AES rounds run, two read ports of the block store gather the 16 source bytes.
// A finished result sits in an output register; if the receiver stalls, the next chunk
// is still computed and then waits until the register is free.
// Reset clears the control logic, sets the key to zero and the counter to the fixed IV.
// Key writes reload the counter; words already collected are kept.
module deinterleave_aes_ctr_decrypt_core #(
    parameter int BLOCK_BYTES   = dac_pkg::BLOCK_BYTES_DEF,
    parameter int QUARTER_BYTES = dac_pkg::QUARTER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_cipher_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_plain_high,
    output logic [63:0] o_plain_low,
    output logic        o_block_last
);
    `include "deinterleave_aes_ctr_decrypt_core_macros.svh"

    localparam int WORDS  = BLOCK_BYTES / 8;
    localparam int WW     = $clog2(WORDS);
    localparam int CHUNKS = BLOCK_BYTES / 16;
    localparam int CW     = $clog2(CHUNKS);
    localparam int BW     = $clog2(BLOCK_BYTES);
    localparam int SW     = $clog2(3 * QUARTER_BYTES + BLOCK_BYTES);

    typedef enum logic {S_COLLECT, S_RUN} t_state;

    t_state         r_state;
    logic [WW-1:0]  r_wc;
    logic [CW-1:0]  r_chunk;
    logic [3:0]     r_rnd;
    logic [3:0]     r_gk;
    logic           r_rdv;
    logic [2:0]     r_slot;
    logic [127:0]   r_key, r_ctr, r_s, r_rk;
    logic [63:0]    r_mem [WORDS];
    logic [63:0]    r_rd0, r_rd1;
    logic [2:0]     r_off0, r_off1;
    logic [7:0]     r_data [16];

    logic           in_acc, issue, fin, load_out, start, last_word, last_chunk;
    logic           hold_last, idle_collect;
    logic [127:0]   rk_next, merged;
    logic [31:0]    lane_in [4];
    logic [31:0]    lane_out [4];
    logic [SW-1:0]  src0, src1;
    logic [BW-1:0]  idx0, idx1;
    logic [3:0]     j0, j1;
    logic [127:0]   plain;

    assign o_in_ready = (r_state == S_COLLECT);
    assign in_acc     = i_in_valid && o_in_ready;
    assign last_word  = (r_wc == WW'(WORDS - 1));
    assign last_chunk = (r_chunk == CW'(CHUNKS - 1));
    assign issue      = (r_state == S_RUN) && !r_gk[3];
    assign fin        = (r_state == S_RUN) && (r_rnd == 4'd11) && r_gk[3] && !r_rdv;
    assign load_out   = fin && (!o_out_valid || i_out_ready);
    assign start      = (in_acc && last_word) || (load_out && !last_chunk);

    // Source byte of output byte p = 16*chunk + j is quarter (j mod 4), offset 4*chunk + j/4.
    assign j0   = {r_gk[2:0], 1'b0};
    assign j1   = {r_gk[2:0], 1'b1};
    assign src0 = SW'(j0[1:0]) * SW'(QUARTER_BYTES) + SW'({r_chunk, 2'b00}) + SW'(j0[3:2]);
    assign src1 = SW'(j1[1:0]) * SW'(QUARTER_BYTES) + SW'({r_chunk, 2'b00}) + SW'(j1[3:2]);
    assign idx0 = BW'(src0 % BLOCK_BYTES);
    assign idx1 = BW'(src1 % BLOCK_BYTES);

    // ShiftRows is wiring ahead of the lanes; lane c sees the shifted column c.
    for (genvar c = 0; c < 4; c++) begin : g_lane
        for (genvar i = 0; i < 4; i++) begin : g_byte
            assign lane_in[c][31-8*i -: 8] = r_s[127 - 8*(i + 4*((c + i) % 4)) -: 8];
        end
        dac_col_lane u_lane (
            .i_col (lane_in[c]),
            .i_mix (r_rnd != 4'd10),
            .o_col (lane_out[c])
        );
        assign merged[127-32*c -: 32] = lane_out[c] ^ rk_next[127-32*c -: 32];
    end

    dac_key_step u_key_step (
        .i_rk   (r_rk),
        .i_rcon (dac_pkg::rcon_of(r_rnd)),
        .o_rk   (rk_next)
    );

    for (genvar j = 0; j < 16; j++) begin : g_plain
        assign plain[8*j +: 8] = r_data[j] ^ r_s[127 - 8*j -: 8];
    end

    // Control: state, counters, key, counter and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_wc        <= '0;
            r_chunk     <= '0;
            r_rnd       <= '0;
            r_gk        <= '0;
            r_rdv       <= 1'b0;
            r_key       <= '0;
            r_ctr       <= {dac_pkg::IV_HIGH, dac_pkg::IV_LOW};
            o_out_valid <= 1'b0;
        end else begin
            r_rdv <= issue;
            if (issue) begin
                r_gk <= r_gk + 4'd1;
            end
            if ((r_state == S_RUN) && (r_rnd != 4'd0) && (r_rnd != 4'd11)) begin
                r_rnd <= r_rnd + 4'd1;
            end
            if (in_acc) begin
                r_wc <= last_word ? '0 : r_wc + WW'(1);
                if (last_word) begin
                    r_state <= S_RUN;
                end
            end
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (load_out) begin
                o_out_valid <= 1'b1;
                if (last_chunk) begin
                    r_chunk <= '0;
                    r_state <= S_COLLECT;
                end else begin
                    r_chunk <= r_chunk + CW'(1);
                end
            end
            if (start) begin
                r_rnd <= 4'd1;
                r_gk  <= '0;
                r_ctr <= r_ctr + 128'd1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dac_pkg::CFG_KEY_HIGH: r_key[127:64] <= i_cfg_data;
                    dac_pkg::CFG_KEY_LOW:  r_key[63:0]   <= i_cfg_data;
                    default:               r_key         <= r_key;
                endcase
                r_ctr <= {dac_pkg::IV_HIGH, dac_pkg::IV_LOW};
            end
        end
    end

    // Datapath: block store, gather reads, AES state and result registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_wc] <= i_cipher_word;
        end
        r_rd0  <= r_mem[idx0[BW-1:3]];
        r_rd1  <= r_mem[idx1[BW-1:3]];
        r_off0 <= idx0[2:0];
        r_off1 <= idx1[2:0];
        r_slot <= r_gk[2:0];
        if (r_rdv) begin
            r_data[{r_slot, 1'b0}] <= r_rd0[8*r_off0 +: 8];
            r_data[{r_slot, 1'b1}] <= r_rd1[8*r_off1 +: 8];
        end
        if (start) begin
            r_s  <= r_ctr ^ r_key;
            r_rk <= r_key;
        end else if ((r_rnd != 4'd0) && (r_rnd != 4'd11)) begin
            r_s  <= merged;
            r_rk <= rk_next;
        end
        if (load_out) begin
            o_plain_high <= plain[63:0];
            o_plain_low  <= plain[127:64];
            o_block_last <= last_chunk;
        end
    end

    // The final beat of a block may still be waiting while the next block collects.
    assign hold_last    = o_out_valid && o_block_last && (r_state == S_COLLECT);
    assign idle_collect = !o_out_valid && (r_state == S_COLLECT);

    `DAC_ASSERT_NEXT(a_block_full_stops_input, i_clk, i_rst_n, in_acc && last_word, !o_in_ready)
    `DAC_ASSERT_IMPLIES(a_last_back_to_collect, i_clk, i_rst_n, hold_last, r_chunk == '0)
    `DAC_ASSERT_NEXT(a_result_needs_run, i_clk, i_rst_n, idle_collect, !o_out_valid)

endmodule

/* bench/ctr_plain_checker.sv */
`timescale 1ns / 100ps

// Watches the configuration port and both channels of the decrypt core, keeps its own
// copy of the key schedule, counter and gathered words, and checks every output beat.
module ctr_plain_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_cipher_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_plain_high,
    input  logic [63:0] i_plain_low,
    input  logic        i_block_last,
    output int          o_fail_count,
    output int          o_chunks_due
);

    localparam int STORE_WORDS = dac_pkg::BLOCK_BYTES_DEF / 8;
    localparam int CHUNKS      = dac_pkg::BLOCK_BYTES_DEF / 16;
    localparam int QUARTER     = dac_pkg::QUARTER_BYTES_DEF;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } t_plain_chunk;

    localparam logic [7:0] ROUND_CONST [0:9] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    t_plain_chunk plain_chunks_due[$];
    logic [63:0]  key_hi, key_lo;
    logic [63:0]  cipher_words [0:STORE_WORDS-1];
    logic [6:0]   words_held;
    logic [127:0] ctr_value;
    logic [31:0]  sched [0:43];
    int           fails;

    function automatic logic [31:0] sub_bytes32(input logic [31:0] x);
        return {dac_pkg::SBOX[x[31:24]], dac_pkg::SBOX[x[23:16]],
                dac_pkg::SBOX[x[15:8]], dac_pkg::SBOX[x[7:0]]};
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Rebuilds the schedule from the full key; any key write also restarts the counter.
    task automatic expand_schedule();
        logic [31:0] t;
        sched[0] = key_hi[63:32];
        sched[1] = key_hi[31:0];
        sched[2] = key_lo[63:32];
        sched[3] = key_lo[31:0];
        for (int i = 4; i < 44; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = sub_bytes32({t[23:0], t[31:24]}) ^ {ROUND_CONST[i/4 - 1], 24'h0};
            end
            sched[i] = sched[i-4] ^ t;
        end
        ctr_value = {dac_pkg::IV_HIGH, dac_pkg::IV_LOW};
    endtask

    function automatic logic [127:0] ctr_keystream(input logic [127:0] blk);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) begin
            s[i] = blk[127-8*i -: 8] ^ sched[i/4][31-8*(i%4) -: 8];
        end
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) s[i] = dac_pkg::SBOX[s[i]];
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i) % 4)];
            end
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                    t[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    t[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    t[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ sched[4*r + i/4][31-8*(i%4) -: 8];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    // Output byte 4k+m comes from byte m*QUARTER+k of the gathered block.
    task automatic decrypt_block();
        logic [127:0] ks;
        logic [63:0]  hi, lo;
        logic [7:0]   v;
        int           p, src;
        for (int ch = 0; ch < CHUNKS; ch++) begin
            ks = ctr_keystream(ctr_value);
            ctr_value = ctr_value + 128'd1;
            for (int j = 0; j < 16; j++) begin
                p   = ch * 16 + j;
                src = ((p % 4) * QUARTER + p / 4) % dac_pkg::BLOCK_BYTES_DEF;
                v   = cipher_words[src/8][8*(src%8) +: 8] ^ ks[127-8*j -: 8];
                if (j < 8) hi[8*j +: 8] = v;
                else lo[8*(j-8) +: 8] = v;
            end
            plain_chunks_due.push_back('{hi: hi, lo: lo, last: (ch == CHUNKS - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        t_plain_chunk want;
        if (!i_rst_n) begin
            key_hi = '0;
            key_lo = '0;
            words_held = '0;
            plain_chunks_due.delete();
            fails = 0;
            expand_schedule();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == dac_pkg::CFG_KEY_HIGH) key_hi = i_cfg_data;
                else key_lo = i_cfg_data;
                expand_schedule();
            end
            if (i_in_valid && i_in_ready) begin
                cipher_words[words_held] = i_cipher_word;
                words_held = words_held + 7'd1;
                if (words_held == 7'd0) decrypt_block();
            end
            if (i_out_valid && i_out_ready) begin
                if (plain_chunks_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected output beat, actual hi=%h lo=%h last=%b",
                             $time, i_plain_high, i_plain_low, i_block_last);
                end else begin
                    want = plain_chunks_due.pop_front();
                    if (i_plain_high !== want.hi) begin
                        fails++;
                        $display("%0t: plain_high mismatch, expected %h actual %h",
                                 $time, want.hi, i_plain_high);
                    end
                    if (i_plain_low !== want.lo) begin
                        fails++;
                        $display("%0t: plain_low mismatch, expected %h actual %h",
                                 $time, want.lo, i_plain_low);
                    end
                    if (i_block_last !== want.last) begin
                        fails++;
                        $display("%0t: block_last mismatch, expected %b actual %b",
                                 $time, want.last, i_block_last);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_chunks_due <= plain_chunks_due.size();
    end

endmodule

/* bench/deinterleave_aes_ctr_decrypt_core_tb.sv */
`timescale 1ns / 100ps

// Top of the bench: makes the clock, reset, key writes and ciphertext beats, drives the
// output-side ready, and gives the verdict from the checker's failure count.
module deinterleave_aes_ctr_decrypt_core_tb;

    // Generous bound on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT = 600000;
    // One long receiver hold-off, long enough to fill the core and stall its input.
    localparam int LONG_HOLD   = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_cipher_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_plain_high;
    logic [63:0] o_plain_low;
    logic        o_block_last;

    int fail_count;
    int chunks_due;
    int cycles = 0;
    bit tx_steady;
    bit rx_steady;
    bit hold_req;

    always #5 i_clk = ~i_clk;

    deinterleave_aes_ctr_decrypt_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cipher_word (i_cipher_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_plain_high  (o_plain_high),
        .o_plain_low   (o_plain_low),
        .o_block_last  (o_block_last)
    );

    ctr_plain_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_cipher_word (i_cipher_word),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_plain_high  (o_plain_high),
        .i_plain_low   (o_plain_low),
        .i_block_last  (o_block_last),
        .o_fail_count  (fail_count),
        .o_chunks_due  (chunks_due)
    );

    // Mostly no gap or a short one, now and then a long one.
    function automatic int gap_cycles();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 11) return 0;
        if (pick < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random 64-bit ciphertext, with all-zero and all-one words mixed in.
    function automatic logic [63:0] cipher_pick();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return 64'h0;
        if (pick == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    // Drives one ciphertext beat and holds it until the core takes it. Valid is only
    // dropped when a gap follows, so back-to-back beats never toggle it within a step.
    task automatic send_word(input logic [63:0] w);
        int gap;
        i_in_valid    <= 1'b1;
        i_cipher_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        gap = tx_steady ? 0 : gap_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Writes one or both key halves on consecutive cycles.
    task automatic write_key(input bit do_hi, input bit do_lo,
                             input logic [63:0] hi, input logic [63:0] lo);
        if (do_hi) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= dac_pkg::CFG_KEY_HIGH;
            i_cfg_data  <= hi;
            @(posedge i_clk);
        end
        if (do_lo) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= dac_pkg::CFG_KEY_LOW;
            i_cfg_data  <= lo;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every predicted chunk has come out, then lets the core settle.
    // The checker publishes its count through a register, hence the lead-in before polling it.
    task automatic drain();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (chunks_due != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Receiver side: random stalls, one long hold-off on request, or always ready.
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!rx_steady) stall_left = gap_cycles();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [63:0] khi, klo;
        int          count;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        hold_req      = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= dac_pkg::CFG_KEY_HIGH;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_cipher_word <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats under the reset key: extremes, alternating and walking bits.
        send_word(64'h0);
        send_word('1);
        send_word(64'h5555_5555_5555_5555);
        send_word(64'haaaa_aaaa_aaaa_aaaa);
        send_word(64'h0123_4567_89ab_cdef);
        send_word(64'hfedc_ba98_7654_3210);
        send_word(64'h8000_0000_0000_0000);
        send_word(64'h0000_0000_0000_0001);
        for (int b = 0; b < 64; b += 4) send_word(64'h1 << b);

        // A key write in mid-block: gathered words stay, the counter restarts.
        drain();
        write_key(1'b1, 1'b1, '1, '1);

        for (int seg = 0; seg < 6; seg++) begin
            tx_steady = (seg == 2);
            rx_steady = (seg == 2);
            if (seg == 1) hold_req = 1'b1;
            count = $urandom_range(60, 92);
            for (int n = 0; n < count; n++) send_word(cipher_pick());
            // The sender pauses here until every predicted chunk has come out.
            drain();
            khi = {$urandom(), $urandom()};
            klo = {$urandom(), $urandom()};
            case (seg)
                0: write_key(1'b1, 1'b1, 64'h0, 64'h0);
                1: write_key(1'b1, 1'b0, '1, klo);
                2: write_key(1'b0, 1'b1, khi, 64'h0);
                3: write_key(1'b1, 1'b1, '1, 64'h0);
                default: write_key(1'b1, 1'b1, khi, klo);
            endcase
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/dac_pkg.sv
rtl/dac_col_lane.sv
rtl/dac_key_step.sv
rtl/deinterleave_aes_ctr_decrypt_core.sv
bench/ctr_plain_checker.sv
bench/deinterleave_aes_ctr_decrypt_core_tb.sv
